/* src/two_key_priority_queue_top_macros.svh */
// Assertion macros for the two-key priority queue checker
`ifndef TWO_KEY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define TWO_KEY_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TKPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TKPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tkpq_pkg.sv */
// Types, codes and helpers shared across the two-key priority queue
package tkpq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        STS_OK     = 3'd0,
        STS_DUP    = 3'd1,
        STS_LOCKED = 3'd2,
        STS_FULL   = 3'd3,
        STS_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_INSERT,
        S_SHIFT_DOWN,
        S_HEAD,
        S_DONE
    } seq_state_t;

    typedef struct packed
    {
        logic [7:0]  prio;
        logic [7:0]  age;
        logic [31:0] payload;
    } entry_t;

    typedef struct packed
    {
        kind_t       kind;
        entry_t      fresh;
    } cmd_t;

    typedef struct packed
    {
        status_t                  status;
        logic                     is_empty;
        entry_t                   head;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     lock_flag;
    } result_t;

    // true when key a is served before key b
    function automatic logic comes_before(
        input logic [7:0] a_prio,
        input logic [7:0] a_age,
        input logic [7:0] b_prio,
        input logic [7:0] b_age
    );
        logic res;
        if (a_prio != b_prio)
        begin
            res = (a_prio < b_prio);
        end
        else
        begin
            res = (a_age > b_age);
        end
        return res;
    endfunction

endpackage

/* src/tkpq_if.sv */
// Command and response channel interfaces of the two-key priority queue
interface tkpq_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  priority_req;
    logic [7:0]  age;
    logic [31:0] payload;

    modport source (output valid, output kind, output priority_req, output age,
                    output payload, input ready);
    modport sink (input valid, input kind, input priority_req, input age,
                  input payload, output ready);
endinterface

interface tkpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        is_empty;
    logic [7:0]  head_priority;
    logic [7:0]  head_age;
    logic [31:0] head_payload;
    logic [4:0]  entry_count;
    logic        lock_flag;

    modport source (output valid, output status, output is_empty, output head_priority,
                    output head_age, output head_payload, output entry_count,
                    output lock_flag, input ready);
    modport sink (input valid, input status, input is_empty, input head_priority,
                  input head_age, input head_payload, input entry_count,
                  input lock_flag, output ready);
endinterface

/* src/tkpq_ram.sv */
// Generic simple dual-port RAM with registered read
module tkpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tkpq_seq.sv */
// Sequencer: scans, shifts and inserts entries in the sorted entry memory
module tkpq_seq
    import tkpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  cmd_t           cmd_item,
    output logic           ram_we,
    output logic [AW-1:0]  ram_waddr,
    output entry_t         ram_wdata,
    output logic           ram_re,
    output logic [AW-1:0]  ram_raddr,
    input  entry_t         ram_rdata,
    output logic           res_load,
    output result_t        res,
    input  logic           res_free
);

    seq_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           lock_reg, lock_next;
    cmd_t           cmd_reg, cmd_next;
    status_t        status_reg, status_next;
    logic [CW-1:0]  tgt_reg, tgt_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           pend_reg, pend_next;
    logic           dup_reg, dup_next;
    logic [AW-1:0]  wa_reg, wa_next;

    logic [CW-1:0]  tgt_inc;
    logic [CW-1:0]  tgt_dec;
    logic [CW-1:0]  last_idx;
    logic           scan_end;
    logic           up_end;
    logic           down_end;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    assign tgt_inc  = tgt_reg + 1'b1;
    assign tgt_dec  = tgt_reg - 1'b1;
    assign last_idx = count_reg - 1'b1;
    assign scan_end = (tgt_reg == count_reg) && !pend_reg;
    assign up_end   = (tgt_reg == pos_reg) && !pend_reg;
    assign down_end = (tgt_reg == last_idx) && !pend_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_item.kind == KIND_POP)
                    begin
                        state_next = (count_reg > CW'(1)) ? S_SHIFT_DOWN : S_HEAD;
                    end
                    else if (lock_reg)
                    begin
                        state_next = S_HEAD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    if (dup_reg || (count_reg == CW'(DEPTH)))
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_SHIFT_UP;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                if (up_end)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_HEAD;
            end
            S_SHIFT_DOWN:
            begin
                if (down_end)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        lock_next   = lock_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        tgt_next    = tgt_reg;
        pos_next    = pos_reg;
        pend_next   = 1'b0;
        dup_next    = dup_reg;
        wa_next     = wa_reg;
        cmd_ready   = 1'b0;
        res_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next    = cmd_item;
                    tgt_next    = '0;
                    pos_next    = '0;
                    dup_next    = 1'b0;
                    status_next = STS_OK;
                    if (cmd_item.kind == KIND_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                        end
                    end
                    else if (lock_reg)
                    begin
                        status_next = STS_LOCKED;
                    end
                end
            end
            S_SCAN:
            begin
                if (tgt_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = tgt_reg[AW-1:0];
                    tgt_next  = tgt_inc;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if ((ram_rdata.prio == cmd_reg.fresh.prio) &&
                        (ram_rdata.age == cmd_reg.fresh.age))
                    begin
                        dup_next = 1'b1;
                    end
                    if (!comes_before(cmd_reg.fresh.prio, cmd_reg.fresh.age,
                                      ram_rdata.prio, ram_rdata.age))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                if (scan_end)
                begin
                    if (dup_reg)
                    begin
                        lock_next   = 1'b1;
                        status_next = STS_DUP;
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        tgt_next = count_reg;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                if (tgt_reg != pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = tgt_dec[AW-1:0];
                    wa_next   = tgt_reg[AW-1:0];
                    tgt_next  = tgt_dec;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
            end
            S_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = cmd_reg.fresh;
                count_next = count_reg + 1'b1;
            end
            S_SHIFT_DOWN:
            begin
                if (tgt_reg != last_idx)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = tgt_inc[AW-1:0];
                    wa_next   = tgt_reg[AW-1:0];
                    tgt_next  = tgt_inc;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (down_end)
                begin
                    count_next = last_idx;
                end
            end
            S_HEAD:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_DONE:
            begin
                res_load = res_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign count_wide      = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign res.status      = status_reg;
    assign res.is_empty    = (count_reg == '0);
    assign res.head        = (count_reg == '0) ? '0 : ram_rdata;
    assign res.entry_count = count_wide[COUNT_OUT_W-1:0];
    assign res.lock_flag   = lock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lock_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lock_reg  <= lock_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        tgt_reg    <= tgt_next;
        pos_reg    <= pos_next;
        dup_reg    <= dup_next;
        wa_reg     <= wa_next;
    end

endmodule

/* src/tkpq_out_reg.sv */
// Response output register: holds one result beat until taken
module tkpq_out_reg
    import tkpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        free,
    tkpq_rsp_if.source  rsp
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.status        = data_reg.status;
    assign rsp.is_empty      = data_reg.is_empty;
    assign rsp.head_priority = data_reg.head.prio;
    assign rsp.head_age      = data_reg.head.age;
    assign rsp.head_payload  = data_reg.head.payload;
    assign rsp.entry_count   = data_reg.entry_count;
    assign rsp.lock_flag     = data_reg.lock_flag;

endmodule

/* src/two_key_priority_queue_top.sv */
// Two-key sorted priority queue, top level
//
// Holds up to DEPTH entries sorted by priority (lower first) and, on equal
// priority, by age (greater first). One command is worked at a time; every
// command returns one response beat with status, head entry, count and lock.
// The entries sit in one memory with a single read and a single write port,
// so the time per command follows the number of entries touched: a push
// scans every entry for a duplicate and its insert point, then shifts the
// tail up one place (a push is refused without a scan while locked); a pop
// shifts the remaining entries down. The next command is taken while the
// previous response still waits in the output register. No clearing pass
// runs after reset.
module two_key_priority_queue_top
    import tkpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tkpq_cmd_if.sink    cmd,
    tkpq_rsp_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);

    cmd_t          cmd_item;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;
    logic          res_load;
    result_t       res;
    logic          res_free;

    assign cmd_item.kind          = kind_t'(cmd.kind);
    assign cmd_item.fresh.prio    = cmd.priority_req;
    assign cmd_item.fresh.age     = cmd.age;
    assign cmd_item.fresh.payload = cmd.payload;

    tkpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tkpq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_item  (cmd_item),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_load  (res_load),
        .res       (res),
        .res_free  (res_free)
    );

    tkpq_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .res   (res),
        .free  (res_free),
        .rsp   (rsp)
    );

endmodule

/* src/tkpq_checker.sv */
// Port-level checker for the two-key priority queue, with its bind
`include "two_key_priority_queue_top_macros.svh"

module tkpq_checker
    import tkpq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic        is_empty,
    input logic [7:0]  head_priority,
    input logic [7:0]  head_age,
    input logic [31:0] head_payload,
    input logic [4:0]  entry_count,
    input logic        lock_flag
);

    `TKPQ_ASSERT_NOW(a_empty_count, rsp_valid && is_empty, entry_count == 5'd0, "empty beat with nonzero count")
    `TKPQ_ASSERT_NOW(a_empty_head, rsp_valid && is_empty, (head_priority == 8'd0) && (head_age == 8'd0) && (head_payload == 32'd0), "empty beat with nonzero head")
    `TKPQ_ASSERT_NOW(a_lock_status, rsp_valid && ((status == STS_DUP) || (status == STS_LOCKED)), lock_flag, "duplicate or locked status without lock")
    `TKPQ_ASSERT_NOW(a_pop_empty, rsp_valid && (status == STS_EMPTY), is_empty, "pop on empty left entries")
    `TKPQ_ASSERT_NEXT(a_hold_beat, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(head_payload) && $stable(entry_count), "stalled beat changed")

endmodule

bind two_key_priority_queue_top tkpq_checker u_tkpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .is_empty      (rsp.is_empty),
    .head_priority (rsp.head_priority),
    .head_age      (rsp.head_age),
    .head_payload  (rsp.head_payload),
    .entry_count   (rsp.entry_count),
    .lock_flag     (rsp.lock_flag)
);
